// ===== hdl/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

    localparam logic [11:0] HUE_MAX  = 12'd3599;
    localparam logic [9:0]  SEC_SPAN = 10'd600;
    localparam logic [7:0]  FULL_SCL = 8'd255;
    localparam logic [17:0] SEC_DEN  = 18'd153000;
    // floor(2^32 / 153000); quotient estimate is exact or one low
    localparam logic [14:0] SEC_RECIP = 15'd28071;
    localparam int          RECIP_SH  = 32;

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_sector;

    typedef struct packed {
        t_sector    sector;
        logic [7:0] val;
        logic [7:0] tert;
    } t_side;

endpackage

// ===== hdl/hsv2rgb_sector.sv =====
module hsv2rgb_sector
    import hsv2rgb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [11:0] i_hue,
    input  logic [7:0]  i_saturation,
    input  logic [7:0]  i_brightness,
    output t_sector     o_sector,
    output logic [9:0]  o_rem,
    output logic [7:0]  o_sat,
    output logic [7:0]  o_val
);

    localparam logic [11:0] B1 = 12'(SEC_SPAN);
    localparam logic [11:0] B2 = 12'(2 * SEC_SPAN);
    localparam logic [11:0] B3 = 12'(3 * SEC_SPAN);
    localparam logic [11:0] B4 = 12'(4 * SEC_SPAN);
    localparam logic [11:0] B5 = 12'(5 * SEC_SPAN);

    logic [11:0] hue_c;
    logic [11:0] base;
    logic [11:0] n_rem;
    t_sector     n_sector;

    t_sector     r_sector;
    logic [9:0]  r_rem;
    logic [7:0]  r_sat;
    logic [7:0]  r_val;

    always_comb begin
        hue_c = (i_hue > HUE_MAX) ? HUE_MAX : i_hue;
        if (hue_c >= B5) begin
            n_sector = SEC_MR;
            base     = B5;
        end else if (hue_c >= B4) begin
            n_sector = SEC_BM;
            base     = B4;
        end else if (hue_c >= B3) begin
            n_sector = SEC_CB;
            base     = B3;
        end else if (hue_c >= B2) begin
            n_sector = SEC_GC;
            base     = B2;
        end else if (hue_c >= B1) begin
            n_sector = SEC_YG;
            base     = B1;
        end else begin
            n_sector = SEC_RY;
            base     = 12'd0;
        end
        n_rem = hue_c - base;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sector <= n_sector;
            r_rem    <= n_rem[9:0];
            r_sat    <= i_saturation;
            r_val    <= i_brightness;
        end
    end

    assign o_sector = r_sector;
    assign o_rem    = r_rem;
    assign o_sat    = r_sat;
    assign o_val    = r_val;

endmodule

// ===== hdl/hsv2rgb_levels.sv =====
module hsv2rgb_levels
    import hsv2rgb_pkg::*;
(
    input  logic        i_clk,
    input  logic [1:0]  i_en,
    input  t_sector     i_sector,
    input  logic [9:0]  i_rem,
    input  logic [7:0]  i_sat,
    input  logic [7:0]  i_val,
    output logic [25:0] o_num,
    output t_side       o_side
);

    logic [9:0]  arc;
    logic [17:0] n_sd;
    logic [15:0] n_tn;
    logic [25:0] n_num;
    logic [16:0] tsum;
    t_side       n_side;

    t_sector     r_sector;
    logic [7:0]  r_val;
    logic [17:0] r_sd;
    logic [15:0] r_tn;
    logic [25:0] r_num;
    t_side       r_side;

    // stage 2: s * arc (rem if sector odd, else 600 - rem), v * (255 - s)
    always_comb begin
        arc  = i_sector[0] ? i_rem : (SEC_SPAN - i_rem);
        n_sd = i_sat * arc;
        n_tn = i_val * (FULL_SCL - i_sat);
    end

    // stage 3: secondary numerator, tertiary = tn / 255 (exact below 65280)
    always_comb begin
        n_num         = r_val * (SEC_DEN - r_sd);
        tsum          = 17'(r_tn) + 17'(r_tn[15:8]) + 17'd1;
        n_side.sector = r_sector;
        n_side.val    = r_val;
        n_side.tert   = tsum[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sector <= i_sector;
            r_val    <= i_val;
            r_sd     <= n_sd;
            r_tn     <= n_tn;
        end
        if (i_en[1]) begin
            r_num  <= n_num;
            r_side <= n_side;
        end
    end

    assign o_num  = r_num;
    assign o_side = r_side;

endmodule

// ===== hdl/hsv2rgb_div.sv =====
module hsv2rgb_div
    import hsv2rgb_pkg::*;
(
    input  logic        i_clk,
    input  logic [1:0]  i_en,
    input  logic [25:0] i_num,
    input  t_side       i_side,
    output logic [25:0] o_num,
    output logic [7:0]  o_qe,
    output logic [25:0] o_qd,
    output t_side       o_side
);

    logic [40:0] n_prod;
    logic [25:0] n_qd;

    logic [25:0] r_num4;
    logic [7:0]  r_qe4;
    t_side       r_side4;
    logic [25:0] r_num5;
    logic [7:0]  r_qe5;
    logic [25:0] r_qd5;
    t_side       r_side5;

    always_comb begin
        n_prod = i_num * SEC_RECIP;
        n_qd   = r_qe4 * SEC_DEN;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_num4  <= i_num;
            r_qe4   <= n_prod[RECIP_SH +: 8];
            r_side4 <= i_side;
        end
        if (i_en[1]) begin
            r_num5  <= r_num4;
            r_qe5   <= r_qe4;
            r_qd5   <= n_qd;
            r_side5 <= r_side4;
        end
    end

    assign o_num  = r_num5;
    assign o_qe   = r_qe5;
    assign o_qd   = r_qd5;
    assign o_side = r_side5;

endmodule

// ===== hdl/hsv_to_rgb_converter_core.sv =====
// HSV to RGB pixel converter.
// An accepted input beat passes through the registered stages 1 to 6 to its output beat.
// Throughput: one beat per cycle while i_stall is low; a six-stage pipeline with per-stage valid bits.
// Reset (synchronous, active low) clears all valid bits; the pipeline is empty
// and ready in the cycle after reset is released.
module hsv_to_rgb_converter_core
    import hsv2rgb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [11:0] i_hue,
    input  logic [7:0]  i_saturation,
    input  logic [7:0]  i_brightness,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue
);

    localparam logic [25:0] RR_LIM = 26'(2 * SEC_DEN);

    logic [6:1]  en;
    logic [6:1]  r_vld;

    t_sector     s1_sector;
    logic [9:0]  s1_rem;
    logic [7:0]  s1_sat;
    logic [7:0]  s1_val;
    logic [25:0] s3_num;
    t_side       s3_side;
    logic [25:0] s5_num;
    logic [7:0]  s5_qe;
    logic [25:0] s5_qd;
    t_side       s5_side;

    logic [25:0] n_rr;
    logic [7:0]  n_sec;
    logic [7:0]  n_red;
    logic [7:0]  n_green;
    logic [7:0]  n_blue;

    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;

    // a stage moves when it is empty or the next one moves
    always_comb begin
        en[6] = !r_vld[6] || !i_stall;
        en[5] = !r_vld[5] || en[6];
        en[4] = !r_vld[4] || en[5];
        en[3] = !r_vld[3] || en[4];
        en[2] = !r_vld[2] || en[3];
        en[1] = !r_vld[1] || en[2];
    end

    assign o_stall = !en[1];

    hsv2rgb_sector u_sector (
        .i_clk        (i_clk),
        .i_en         (en[1]),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_sector     (s1_sector),
        .o_rem        (s1_rem),
        .o_sat        (s1_sat),
        .o_val        (s1_val)
    );

    hsv2rgb_levels u_levels (
        .i_clk    (i_clk),
        .i_en     (en[3:2]),
        .i_sector (s1_sector),
        .i_rem    (s1_rem),
        .i_sat    (s1_sat),
        .i_val    (s1_val),
        .o_num    (s3_num),
        .o_side   (s3_side)
    );

    hsv2rgb_div u_div (
        .i_clk  (i_clk),
        .i_en   (en[5:4]),
        .i_num  (s3_num),
        .i_side (s3_side),
        .o_num  (s5_num),
        .o_qe   (s5_qe),
        .o_qd   (s5_qd),
        .o_side (s5_side)
    );

    // quotient correction and channel permutation
    always_comb begin
        n_rr  = s5_num - s5_qd;
        n_sec = (n_rr >= 26'(SEC_DEN)) ? (s5_qe + 8'd1) : s5_qe;
        case (s5_side.sector)
            SEC_RY: begin
                n_red = s5_side.val;  n_green = n_sec;        n_blue = s5_side.tert;
            end
            SEC_YG: begin
                n_red = n_sec;        n_green = s5_side.val;  n_blue = s5_side.tert;
            end
            SEC_GC: begin
                n_red = s5_side.tert; n_green = s5_side.val;  n_blue = n_sec;
            end
            SEC_CB: begin
                n_red = s5_side.tert; n_green = n_sec;        n_blue = s5_side.val;
            end
            SEC_BM: begin
                n_red = n_sec;        n_green = s5_side.tert; n_blue = s5_side.val;
            end
            default: begin
                n_red = s5_side.val;  n_green = s5_side.tert; n_blue = n_sec;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) r_vld[1] <= i_valid;
            if (en[2]) r_vld[2] <= r_vld[1];
            if (en[3]) r_vld[3] <= r_vld[2];
            if (en[4]) r_vld[4] <= r_vld[3];
            if (en[5]) r_vld[5] <= r_vld[4];
            if (en[6]) r_vld[6] <= r_vld[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_valid = r_vld[6];
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

`ifndef ASSERT_OFF
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld) && i_stall)
        else $error("input stalled with a bubble in the pipeline");

    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[5] && en[6]) |=> o_valid)
        else $error("stage 5 beat did not reach the output");

    a_quot_est: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> (s5_qd <= s5_num) && (n_rr < RR_LIM))
        else $error("reciprocal quotient estimate out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[5] && !en[5]) |=> r_vld[5] && $stable(s5_qe))
        else $error("stalled stage 5 beat changed");
`endif

endmodule
